[rtl/recent_user_list_with_codes_core_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef RECENT_USER_LIST_WITH_CODES_CORE_MACROS_SVH
`define RECENT_USER_LIST_WITH_CODES_CORE_MACROS_SVH

// Same-cycle implication.
`define RUL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RUL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rul_pkg.sv]
package rul_pkg;

    localparam int NUM_USERS_DEF = 5;
    localparam int ID_W          = 32;
    localparam int CODE_W        = 8;
    localparam int REQ_W         = 2;
    localparam int CNT_OUT_W     = 3;

    // Request codes; the fourth code is unused and leaves the table unchanged with req_ok low.
    typedef enum logic [REQ_W-1:0] {
        REQ_SET_OWNER = 2'd0,
        REQ_CHECK     = 2'd1,
        REQ_SET_CODE  = 2'd2
    } req_type_t;

    typedef struct packed {
        logic                 req_ok;
        logic [ID_W-1:0]      owner_id;
        logic [CODE_W-1:0]    owner_code;
        logic [CNT_OUT_W-1:0] user_count;
        logic                 was_present;
        logic                 evicted;
    } rsp_t;

endpackage

[rtl/rul_req_if.sv]
interface rul_req_if;
    import rul_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   user_id;
    logic [CODE_W-1:0] entered_code;

    modport source (output valid, req_type, user_id, entered_code, input ready);
    modport sink   (input valid, req_type, user_id, entered_code, output ready);
endinterface

[rtl/rul_rsp_if.sv]
interface rul_rsp_if;
    import rul_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_ok;
    logic [ID_W-1:0]      owner_id;
    logic [CODE_W-1:0]    owner_code;
    logic [CNT_OUT_W-1:0] user_count;
    logic                 was_present;
    logic                 evicted;

    modport source (
        output valid, req_ok, owner_id, owner_code, user_count, was_present, evicted,
        input  ready
    );
    modport sink (
        input  valid, req_ok, owner_id, owner_code, user_count, was_present, evicted,
        output ready
    );
endinterface

[rtl/recent_user_list_with_codes_core.sv]
// Recent-user table with per-user code bytes, kept in move-to-front order.
// Requests enter through a one-deep input register; the table compares all
// slots in parallel, shifts entries and forms the result combinationally,
// and the result lands in an output register. One request is accepted
// every clock while the result side keeps taking beats. The
// compare-and-shift pass over NUM_USERS slots is combinational. The table
// is empty after reset. new_user_code is written through cfg_wr_en /
// cfg_wr_data; the user writes it only while no request is in flight,
// which the block itself does not enforce.
`include "recent_user_list_with_codes_core_macros.svh"

module recent_user_list_with_codes_core #(
    parameter int NUM_USERS = rul_pkg::NUM_USERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rul_pkg::CODE_W-1:0] cfg_wr_data,
    rul_req_if.sink                    req,
    rul_rsp_if.source                  rsp
);
    import rul_pkg::*;

    // Default code for newly inserted users.
    logic [CODE_W-1:0] new_code_reg;

    // Input register: holds one request beat until the table takes it.
    logic              in_valid_reg;
    logic [REQ_W-1:0]  in_type_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [CODE_W-1:0] in_code_reg;

    // Output register: holds one result beat until the sink takes it.
    logic out_valid_reg;
    rsp_t out_reg;

    rsp_t table_rsp;
    logic advance;

    // Advance the request into the table when the output register is free
    // or drains in this same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_code_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            new_code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // Capture payload on every accepted beat; no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_id_reg   <= req.user_id;
            in_code_reg <= req.entered_code;
        end
    end

    rul_table #(
        .NUM_USERS(NUM_USERS)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (advance),
        .req_type     (in_type_reg),
        .user_id      (in_id_reg),
        .entered_code (in_code_reg),
        .new_user_code(new_code_reg),
        .result       (table_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= table_rsp;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.req_ok      = out_reg.req_ok;
    assign rsp.owner_id    = out_reg.owner_id;
    assign rsp.owner_code  = out_reg.owner_code;
    assign rsp.user_count  = out_reg.user_count;
    assign rsp.was_present = out_reg.was_present;
    assign rsp.evicted     = out_reg.evicted;

    // Never drop a waiting result by advancing over it.
    `RUL_ASSERT_NOW(a_no_overwrite, out_valid_reg && !rsp.ready, !advance,
        "result overwritten while stalled")
    // Every table pass yields a result beat next cycle.
    `RUL_ASSERT_NEXT(a_pass_gives_beat, advance, out_valid_reg,
        "table pass without result beat")
    // Hold a stalled result beat in place.
    `RUL_ASSERT_NEXT(a_hold_stalled, out_valid_reg && !rsp.ready,
        out_valid_reg && $stable(out_reg), "stalled result beat changed")

endmodule

[rtl/rul_table.sv]
`include "recent_user_list_with_codes_core_macros.svh"

module rul_table #(
    parameter int NUM_USERS = rul_pkg::NUM_USERS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [rul_pkg::REQ_W-1:0]  req_type,
    input  logic [rul_pkg::ID_W-1:0]   user_id,
    input  logic [rul_pkg::CODE_W-1:0] entered_code,
    input  logic [rul_pkg::CODE_W-1:0] new_user_code,
    output rul_pkg::rsp_t              result
);
    import rul_pkg::*;

    localparam int CNT_W = $clog2(NUM_USERS + 1);

    logic [ID_W-1:0]   id_reg    [NUM_USERS];
    logic [ID_W-1:0]   id_next   [NUM_USERS];
    logic [CODE_W-1:0] code_reg  [NUM_USERS];
    logic [CODE_W-1:0] code_next [NUM_USERS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [NUM_USERS-1:0] hit;
    logic [NUM_USERS-1:0] clear_below;
    logic [CODE_W-1:0]    hit_code;
    logic                 present;
    logic                 full;

    // Compare all valid slots; the first hit supplies its code.
    always_comb
    begin
        logic seen;
        seen     = 1'b0;
        hit_code = '0;
        for (int i = 0; i < NUM_USERS; i++)
        begin
            hit[i]         = (CNT_W'(i) < count_reg) && (id_reg[i] == user_id);
            clear_below[i] = !seen;
            if (hit[i] && !seen)
            begin
                hit_code = hit_code | code_reg[i];
            end
            seen = seen | hit[i];
        end
    end

    assign present = |hit;
    assign full    = (count_reg == CNT_W'(NUM_USERS));

    always_comb
    begin
        for (int k = 0; k < NUM_USERS; k++)
        begin
            id_next[k]   = id_reg[k];
            code_next[k] = code_reg[k];
        end
        count_next         = count_reg;
        result.req_ok      = 1'b0;
        result.was_present = 1'b0;
        result.evicted     = 1'b0;

        unique case (req_type)
            REQ_SET_OWNER:
            begin
                // Push down everything above the hit, or above the insertion point.
                for (int k = NUM_USERS - 1; k > 0; k--)
                begin
                    if (present ? clear_below[k] : (CNT_W'(k) <= count_reg))
                    begin
                        id_next[k]   = id_reg[k-1];
                        code_next[k] = code_reg[k-1];
                    end
                end
                id_next[0]         = user_id;
                code_next[0]       = present ? hit_code : new_user_code;
                count_next         = (present || full) ? count_reg
                                                       : CNT_W'(count_reg + 1'b1);
                result.req_ok      = 1'b1;
                result.was_present = present;
                result.evicted     = !present && full;
            end
            REQ_CHECK:
            begin
                result.req_ok = (count_reg != '0) && (code_reg[0] == entered_code);
            end
            REQ_SET_CODE:
            begin
                if (count_reg != '0)
                begin
                    code_next[0]  = entered_code;
                    result.req_ok = 1'b1;
                end
            end
            default:
            begin
                result.req_ok = 1'b0;
            end
        endcase

        result.owner_id   = (count_next != '0) ? id_next[0] : '0;
        result.owner_code = (count_next != '0) ? code_next[0] : '0;
        result.user_count = CNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            for (int k = 0; k < NUM_USERS; k++)
            begin
                id_reg[k]   <= id_next[k];
                code_reg[k] <= code_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (go)
        begin
            count_reg <= count_next;
        end
    end

    `RUL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(NUM_USERS),
        "entry count above table depth")
    `RUL_ASSERT_NOW(a_hit_or_evict, go, !(result.was_present && result.evicted),
        "listed user caused an eviction")
    `RUL_ASSERT_NEXT(a_evict_stays_full, go && result.evicted,
        count_reg == CNT_W'(NUM_USERS), "eviction left table not full")

endmodule
